[rtl/core/modexp_pkg.sv]
// ============================================================================
// modexp_pkg
// Shared widths, reset values and the request/response bundles that pass
// between the exponentiation sequencer and the serial modular reducer.
// ============================================================================
`default_nettype none

package modexp_pkg;

    localparam int MOD_W  = 31;        // modulus and residue width
    localparam int IN_W   = 63;        // base and exponent width
    localparam int PROD_W = 2 * MOD_W; // residue product width
    localparam int CNT_W  = 6;         // reducer bit counter width

    localparam logic [MOD_W-1:0] MOD_RESET = MOD_W'(1000000007);

    // Start a reduction of a dividend
    typedef struct packed {
        logic            go;
        logic [IN_W-1:0] dividend;
    } red_req_t;

    // Finished reduction
    typedef struct packed {
        logic             done;
        logic [MOD_W-1:0] remainder;
    } red_rsp_t;

endpackage

`default_nettype wire

[rtl/core/modexp_reduce.sv]
// ============================================================================
// modexp_reduce
// Serial restoring reducer: shifts a 63-bit dividend in one bit per cycle and
// keeps a running remainder below the modulus with one compare and subtract.
// ============================================================================
`default_nettype none

module modexp_reduce (
    input  wire                         clk,
    input  wire                         rst_n,
    input  modexp_pkg::red_req_t        req,
    input  wire [modexp_pkg::MOD_W-1:0] modulus,
    output modexp_pkg::red_rsp_t        rsp
);
    import modexp_pkg::*;

    localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(IN_W - 1);

    logic             run_reg,  run_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg,  cnt_next;
    logic [IN_W-1:0]  dvd_reg,  dvd_next;
    logic [MOD_W-1:0] rem_reg,  rem_next;

    logic [MOD_W:0]   trial;
    logic [MOD_W:0]   diff;

    // Shift in the next dividend bit and subtract the modulus when it fits
    always_comb
    begin
        trial = {rem_reg, dvd_reg[IN_W-1]};
        diff  = trial - {1'b0, modulus};
    end

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        if (req.go)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            dvd_next = req.dividend;
            rem_next = '0;
        end
        else if (run_reg)
        begin
            dvd_next = {dvd_reg[IN_W-2:0], 1'b0};
            if (trial >= {1'b0, modulus})
            begin
                rem_next = diff[MOD_W-1:0];
            end
            else
            begin
                rem_next = trial[MOD_W-1:0];
            end
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == LAST_BIT)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Hold operands
    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.remainder = rem_reg;

endmodule

`default_nettype wire

[rtl/core/modexp_ctrl.sv]
// ============================================================================
// modexp_ctrl
// Square-and-multiply sequencer: scans the exponent from the low bit, forms
// residue products in a 31x31 multiplier and hands each one to the reducer.
// ============================================================================
`default_nettype none

module modexp_ctrl (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         start,
    input  wire [modexp_pkg::IN_W-1:0]  base,
    input  wire [modexp_pkg::IN_W-1:0]  exponent,
    input  wire [modexp_pkg::MOD_W-1:0] modulus,
    output logic                        busy,
    output logic                        done,
    output logic [modexp_pkg::MOD_W-1:0] power,
    output modexp_pkg::red_req_t        red_req,
    input  modexp_pkg::red_rsp_t        red_rsp
);
    import modexp_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_RED  = 2'd2;

    // What the running reduction produces
    localparam logic [1:0] T_BASE = 2'd0;
    localparam logic [1:0] T_ACC  = 2'd1;
    localparam logic [1:0] T_SQR  = 2'd2;

    logic [1:0]       state_reg,  state_next;
    logic [1:0]       tgt_reg,    tgt_next;
    logic             go_reg,     go_next;
    logic             done_reg,   done_next;
    logic [IN_W-1:0]  exp_reg,    exp_next;
    logic [IN_W-1:0]  opnd_reg,   opnd_next;
    logic [MOD_W-1:0] base_reg,   base_next;
    logic [MOD_W-1:0] acc_reg,    acc_next;
    logic [MOD_W-1:0] power_reg,  power_next;

    logic [MOD_W-1:0]  mul_a;
    logic [PROD_W-1:0] prod;
    logic [IN_W-1:0]   exp_shr;

    // Multiply the base by the accumulator or by itself
    always_comb
    begin
        mul_a = (tgt_reg == T_ACC) ? acc_reg : base_reg;
        prod  = {{MOD_W{1'b0}}, mul_a} * {{MOD_W{1'b0}}, base_reg};
    end

    assign exp_shr = {1'b0, exp_reg[IN_W-1:1]};

    // Advance the sequence
    always_comb
    begin
        state_next = state_reg;
        tgt_next   = tgt_reg;
        go_next    = 1'b0;
        done_next  = 1'b0;
        exp_next   = exp_reg;
        opnd_next  = opnd_reg;
        base_next  = base_reg;
        acc_next   = acc_reg;
        power_next = power_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (modulus == '0)
                    begin
                        power_next = '0;
                        done_next  = 1'b1;
                    end
                    else if (exponent == '0)
                    begin
                        power_next = MOD_W'(1);
                        done_next  = 1'b1;
                    end
                    else
                    begin
                        exp_next   = exponent;
                        opnd_next  = base;
                        acc_next   = MOD_W'(1);
                        tgt_next   = T_BASE;
                        go_next    = 1'b1;
                        state_next = S_RED;
                    end
                end
            end
            S_MUL:
            begin
                opnd_next  = {1'b0, prod};
                go_next    = 1'b1;
                state_next = S_RED;
            end
            S_RED:
            begin
                if (red_rsp.done)
                begin
                    case (tgt_reg)
                        T_ACC:
                        begin
                            acc_next = red_rsp.remainder;
                            if (exp_shr == '0)
                            begin
                                power_next = red_rsp.remainder;
                                done_next  = 1'b1;
                                state_next = S_IDLE;
                            end
                            else
                            begin
                                tgt_next   = T_SQR;
                                state_next = S_MUL;
                            end
                        end
                        T_SQR:
                        begin
                            // Drop the used exponent bit
                            base_next  = red_rsp.remainder;
                            exp_next   = exp_shr;
                            tgt_next   = exp_shr[0] ? T_ACC : T_SQR;
                            state_next = S_MUL;
                        end
                        default:
                        begin
                            base_next  = red_rsp.remainder;
                            tgt_next   = exp_reg[0] ? T_ACC : T_SQR;
                            state_next = S_MUL;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            tgt_reg   <= T_BASE;
            go_reg    <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            tgt_reg   <= tgt_next;
            go_reg    <= go_next;
            done_reg  <= done_next;
        end
    end

    // Hold operands and the result beat
    always_ff @(posedge clk)
    begin
        exp_reg   <= exp_next;
        opnd_reg  <= opnd_next;
        base_reg  <= base_next;
        acc_reg   <= acc_next;
        power_reg <= power_next;
    end

    assign busy             = (state_reg != S_IDLE);
    assign done             = done_reg;
    assign power            = power_reg;
    assign red_req.go       = go_reg;
    assign red_req.dividend = opnd_reg;

endmodule

`default_nettype wire

[rtl/core/modular_exponentiation_core.sv]
// ============================================================================
// modular_exponentiation_core
// Computes base^exponent mod modulus by right-to-left square-and-multiply
// with one multiplier and one shared bit-serial reducer.
// ============================================================================
//
//  Channel   Handshake             Payload
//  -------   -------------------   ---------------------------
//  command   start / busy          base[62:0], exponent[62:0]
//  result    done (1-cycle pulse)  power[30:0]
//  config    cfg_valid/cfg_ready   modulus[30:0]
//
//  A reduction holds the sequencer through its request, every dividend bit
//  and done; each product adds a multiply state. After the base reduction
//  each set exponent bit costs a product and each bit below the top set bit
//  a squaring. Exponent zero or modulus zero give done the next cycle.
//  The reducer's bit loop sets the rate. Reset restores modulus 1000000007.
//  The receiver cannot stall: a result beat is lost if not taken on done.
//
`default_nettype none

module modular_exponentiation_core (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         start,
    output logic                        busy,
    input  wire [modexp_pkg::IN_W-1:0]  base,
    input  wire [modexp_pkg::IN_W-1:0]  exponent,
    output logic                        done,
    output logic [modexp_pkg::MOD_W-1:0] power,
    input  wire                         cfg_valid,
    output logic                        cfg_ready,
    input  wire [modexp_pkg::MOD_W-1:0] modulus
);
    import modexp_pkg::*;

    logic [MOD_W-1:0] modulus_reg, modulus_next;
    red_req_t         red_req;
    red_rsp_t         red_rsp;
    logic             ctrl_busy;

    // Take a modulus beat only while no command is running or being started
    assign cfg_ready = ~ctrl_busy & ~start;
    assign busy      = ctrl_busy;

    always_comb
    begin
        modulus_next = modulus_reg;
        if (cfg_valid && cfg_ready)
        begin
            modulus_next = modulus;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= MOD_RESET;
        end
        else
        begin
            modulus_reg <= modulus_next;
        end
    end

    modexp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .base     (base),
        .exponent (exponent),
        .modulus  (modulus_reg),
        .busy     (ctrl_busy),
        .done     (done),
        .power    (power),
        .red_req  (red_req),
        .red_rsp  (red_rsp)
    );

    modexp_reduce u_reduce (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (red_req),
        .modulus (modulus_reg),
        .rsp     (red_rsp)
    );

endmodule

`default_nettype wire

[test/tb.sv]
// ============================================================================
// tb: modular exponentiation core testbench
// Drives base/exponent commands through the start/busy port, rewrites the
// modulus between phases while the core is idle, and checks every power
// pulse against a square-and-multiply predictor kept in a small scoreboard.
// ============================================================================
`timescale 1ns / 1ps

module tb;
    import modexp_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 6_000_000;
    localparam logic [IN_W-1:0] IN_MAX = {IN_W{1'b1}};
    localparam logic [IN_W-1:0] ALT_LO = 63'h5555_5555_5555_5555;
    localparam logic [IN_W-1:0] ALT_HI = 63'h2AAA_AAAA_AAAA_AAAA;
    localparam logic [IN_W-1:0] TOP_BIT = 63'h4000_0000_0000_0000;
    localparam logic [MOD_W-1:0] MOD_MAX = {MOD_W{1'b1}};

    // One owed result with the command that caused it
    typedef struct {
        logic [IN_W-1:0]  base_val;
        logic [IN_W-1:0]  exp_val;
        logic [MOD_W-1:0] power_val;
    } owed_power_t;

    // Scoreboard: predicts powers at the current modulus and checks pulses
    class power_board;
        logic [MOD_W-1:0] modulus_now;
        owed_power_t      owed_powers[$];
        int unsigned      mismatches;

        function new();
            modulus_now = MOD_RESET;
            mismatches  = 0;
        endfunction

        function int unsigned owed();
            return owed_powers.size();
        endfunction

        function void set_modulus(logic [MOD_W-1:0] m);
            modulus_now = m;
        endfunction

        // Square the base and fold it into the product, LSB of exponent first
        function logic [MOD_W-1:0] predict_power(logic [IN_W-1:0] b, logic [IN_W-1:0] e);
            logic [63:0]     acc;
            logic [63:0]     sq;
            logic [63:0]     m;
            logic [IN_W-1:0] rest;
            if (modulus_now == '0)
                return '0;
            m    = {33'd0, modulus_now};
            acc  = 64'd1;
            sq   = {1'b0, b} % m;
            rest = e;
            while (rest != '0)
            begin
                if (rest[0])
                    acc = (acc * sq) % m;
                sq   = (sq * sq) % m;
                rest = rest >> 1;
            end
            return acc[MOD_W-1:0];
        endfunction

        function void note_command(logic [IN_W-1:0] b, logic [IN_W-1:0] e);
            owed_power_t item;
            item.base_val  = b;
            item.exp_val   = e;
            item.power_val = predict_power(b, e);
            owed_powers.insert(owed_powers.size(), item);
        endfunction

        task report_mismatch(string what);
            $display("MISMATCH @%0t: %s", $realtime, what);
            mismatches++;
        endtask

        task check_power(logic [MOD_W-1:0] got);
            owed_power_t item;
            if (owed_powers.size() == 0)
            begin
                report_mismatch($sformatf("power %0d with nothing owed", got));
            end
            else
            begin
                item = owed_powers[0];
                owed_powers.delete(0);
                if (got !== item.power_val)
                    report_mismatch($sformatf("base %0h exp %0h mod %0d: power %0d, want %0d",
                        item.base_val, item.exp_val, modulus_now, got, item.power_val));
            end
        endtask
    endclass

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    logic [IN_W-1:0]  base;
    logic [IN_W-1:0]  exponent;
    logic             done;
    logic [MOD_W-1:0] power;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [MOD_W-1:0] modulus;

    power_board  board;
    bit          steady;
    int unsigned cycles;

    modular_exponentiation_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .base      (base),
        .exponent  (exponent),
        .done      (done),
        .power     (power),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .modulus   (modulus)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Bound the run in case a handshake hangs
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb failed");
            $finish;
        end
    end

    // Check each result beat on its strobe
    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
            board.check_power(power);
    end

    function automatic logic [IN_W-1:0] rand_wide();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[IN_W-1:0];
    endfunction

    // Keep most exponents short so the serial reducer stays fast
    function automatic logic [IN_W-1:0] rand_exponent();
        logic [IN_W-1:0] e;
        int unsigned     pick;
        e    = rand_wide();
        pick = $urandom_range(0, 99);
        if (pick < 3)
            return e;
        if (pick < 8)
            return '0;
        if (pick < 18)
            return e & ((IN_W'(1) << $urandom_range(17, 40)) - IN_W'(1));
        return e & ((IN_W'(1) << $urandom_range(1, 16)) - IN_W'(1));
    endfunction

    function automatic logic [IN_W-1:0] rand_base();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            return rand_wide();
        if (pick < 60)
            return IN_W'($urandom_range(0, 255));
        if (pick < 75)
            return IN_W'(board.modulus_now) * IN_W'($urandom_range(0, 1000));
        return IN_W'($urandom) & IN_W'(MOD_MAX);
    endfunction

    function automatic logic [MOD_W-1:0] pick_modulus();
        case ($urandom_range(0, 6))
            0: return MOD_W'($urandom);
            1: return MOD_W'($urandom_range(2, 100));
            2: return MOD_MAX;
            3: return MOD_W'(1);
            4: return '0;
            5: return MOD_RESET;
            default: return MOD_W'(1) << $urandom_range(1, MOD_W - 1);
        endcase
    endfunction

    // Present one command beat, idling first now and then
    task automatic send_cmd(input logic [IN_W-1:0] b, input logic [IN_W-1:0] e);
        if (!steady && $urandom_range(0, 99) < 20)
        begin
            start <= 1'b0;
            @(posedge clk);
            if ($urandom_range(0, 1) == 1)
                while (busy) @(posedge clk);
            repeat ($urandom_range(0, 6)) @(posedge clk);
        end
        start    <= 1'b1;
        base     <= b;
        exponent <= e;
        @(posedge clk);
        while (busy) @(posedge clk);
        board.note_command(b, e);
    endtask

    // Drop start and hold off until every owed power has come back
    task automatic settle();
        start <= 1'b0;
        while (board.owed() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_modulus(input logic [MOD_W-1:0] m);
        cfg_valid <= 1'b1;
        modulus   <= m;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        board.set_modulus(m);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        board     = new();
        steady    = 1'b0;
        rst_n     <= 1'b0;
        start     <= 1'b0;
        base      <= '0;
        exponent  <= '0;
        cfg_valid <= 1'b0;
        modulus   <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Reset modulus: exponent zero, zero base, extremes, alternating bits
        send_cmd('0, '0);
        send_cmd(IN_MAX, '0);
        send_cmd('0, IN_W'(5));
        send_cmd(IN_MAX, IN_W'(1));
        send_cmd(IN_MAX, IN_MAX);
        send_cmd(IN_W'(1000000007), IN_W'(3));
        send_cmd(IN_W'(2), IN_W'(1000000005));
        send_cmd(ALT_HI, ALT_LO);
        send_cmd(ALT_LO, ALT_HI);
        send_cmd(IN_W'(3), TOP_BIT);
        settle();

        // Modulus one: exponent zero still gives one, anything else zero
        write_modulus(MOD_W'(1));
        send_cmd(IN_W'(7), '0);
        send_cmd(IN_W'(7), IN_W'(9));
        send_cmd(IN_MAX, IN_MAX);
        settle();

        // Modulus zero: power held at zero
        write_modulus('0);
        send_cmd(IN_W'(7), '0);
        send_cmd(IN_MAX, IN_MAX);
        send_cmd(IN_W'(5), IN_W'(3));
        settle();

        // Widest modulus
        write_modulus(MOD_MAX);
        send_cmd(IN_MAX, IN_MAX);
        send_cmd(IN_W'(MOD_MAX) - IN_W'(1), IN_W'(2));
        send_cmd(IN_W'(2), IN_W'(31));
        send_cmd(IN_W'(MOD_MAX), IN_W'(1));
        settle();

        write_modulus(MOD_W'(2));
        send_cmd(IN_W'(3), IN_W'(5));
        send_cmd(IN_W'(4), IN_W'(5));
        settle();

        // Random phases, one of them with no idling
        for (int ph = 0; ph < 6; ph++)
        begin
            steady = (ph == 2);
            if (ph == 0)
                write_modulus({1'b1, (MOD_W-1)'($urandom)});
            else
                write_modulus(pick_modulus());
            repeat (20) send_cmd(rand_base(), rand_exponent());
            settle();
        end

        repeat (20) @(posedge clk);
        if (board.mismatches == 0 && board.owed() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
